// ===== design/tekc_pkg.sv =====
package tekc_pkg;

  localparam int ENTRIES    = 1024;
  localparam int KEY_BITS   = 64;
  localparam int VALUE_BITS = 64;

  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int STAMP_W = 31;
  localparam int SLOT_W  = 10;

  localparam logic [STAMP_W-1:0] STAMP_LIMIT = {STAMP_W{1'b1}};

  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef struct packed {
    logic               action;
    logic [63:0]        key;
    logic [STAMP_W-1:0] stamp;
    logic [63:0]        value;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic               evicted;
    logic [SLOT_W-1:0]  slot;
    logic [63:0]        found_value;
    logic [STAMP_W-1:0] found_stamp;
  } out_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [STAMP_W-1:0]    stamp;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

endpackage

// ===== design/timestamp_evicting_key_cache.sv =====
// Fully associative key cache, oldest-stamp replacement.
// Input: pulse start with in_item while busy is low; the beat is taken at
// that edge. in_item.action selects update (store key/value/stamp) or lookup.
// Output: out_valid is high for exactly one cycle with out_item; the receiver
// cannot stall, so the result must be captured in that cycle.
// Each item scans the occupied slots through an entry RAM with a registered
// read port, one slot per cycle, tracking the first key match and the
// first smallest stamp in the same pass; the write-back (if any) happens in
// the finish state. With slots in use, busy stays high through the scan,
// drain and finish states and out_valid follows in the next cycle; with an
// empty table busy is high only in the finish state, and out_valid follows
// it likewise. A new start is taken in the cycle out_valid is shown, so an
// item is accepted only after the previous one is fully done.
// Reset clears the fill count and control state only; the entry RAM is not
// cleared, since only slots below the fill count are ever used.
module timestamp_evicting_key_cache (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  tekc_pkg::in_t  in_item,
  output logic           out_valid,
  output tekc_pkg::out_t out_item
);
  import tekc_pkg::*;

  entry_t mem [ENTRIES];
  entry_t rd_data_r;

  state_t state_r, state_nxt;
  in_t    req_r, req_nxt;

  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [IDX_W-1:0]   addr_r, addr_nxt;
  logic [IDX_W-1:0]   rd_slot_r, rd_slot_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic               found_r, found_nxt;
  logic [IDX_W-1:0]   found_slot_r, found_slot_nxt;
  logic [VALUE_BITS-1:0] found_val_r, found_val_nxt;
  logic [STAMP_W-1:0] found_stamp_r, found_stamp_nxt;
  logic [STAMP_W-1:0] best_r, best_nxt;
  logic [IDX_W-1:0]   best_slot_r, best_slot_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_r, out_nxt;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r         <= req_nxt;
    addr_r        <= addr_nxt;
    rd_slot_r     <= rd_slot_nxt;
    found_r       <= found_nxt;
    found_slot_r  <= found_slot_nxt;
    found_val_r   <= found_val_nxt;
    found_stamp_r <= found_stamp_nxt;
    best_r        <= best_nxt;
    best_slot_r   <= best_slot_nxt;
    out_r         <= out_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    req_nxt         = req_r;
    fill_nxt        = fill_r;
    addr_nxt        = addr_r;
    rd_slot_nxt     = addr_r;
    rd_vld_nxt      = 1'b0;
    found_nxt       = found_r;
    found_slot_nxt  = found_slot_r;
    found_val_nxt   = found_val_r;
    found_stamp_nxt = found_stamp_r;
    best_nxt        = best_r;
    best_slot_nxt   = best_slot_r;
    out_valid_nxt   = 1'b0;
    out_nxt         = out_r;
    wr_en           = 1'b0;
    wr_addr         = found_slot_r;
    wr_data.key     = req_r.key[KEY_BITS-1:0];
    wr_data.value   = req_r.value[VALUE_BITS-1:0];
    wr_data.stamp   = req_r.stamp;

    // returning read data: first key match and first strictly smaller stamp
    if (rd_vld_r) begin
      if (!found_r && rd_data_r.key == req_r.key[KEY_BITS-1:0]) begin
        found_nxt       = 1'b1;
        found_slot_nxt  = rd_slot_r;
        found_val_nxt   = rd_data_r.value;
        found_stamp_nxt = rd_data_r.stamp;
      end
      if (rd_data_r.stamp < best_r) begin
        best_nxt      = rd_data_r.stamp;
        best_slot_nxt = rd_slot_r;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt       = in_item;
          addr_nxt      = '0;
          found_nxt     = 1'b0;
          best_nxt      = STAMP_LIMIT;
          best_slot_nxt = '0;
          state_nxt     = (fill_r == '0) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_vld_nxt = 1'b1;
        addr_nxt   = addr_r + 1'b1;
        if (CNT_W'(addr_r) + 1'b1 == fill_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        out_valid_nxt       = 1'b1;
        out_nxt.hit         = found_r;
        out_nxt.evicted     = 1'b0;
        out_nxt.slot        = '0;
        out_nxt.found_value = '0;
        out_nxt.found_stamp = '0;
        if (req_r.action == ACT_LOOKUP) begin
          if (found_r) begin
            out_nxt.slot        = SLOT_W'(found_slot_r);
            out_nxt.found_value = 64'(found_val_r);
            out_nxt.found_stamp = found_stamp_r;
          end
        end else begin
          wr_en = 1'b1;
          if (found_r) begin
            wr_addr = found_slot_r;
          end else if (fill_r < CNT_W'(ENTRIES)) begin
            wr_addr  = fill_r[IDX_W-1:0];
            fill_nxt = fill_r + 1'b1;
          end else begin
            wr_addr         = best_slot_r;
            out_nxt.evicted = 1'b1;
          end
          out_nxt.slot = SLOT_W'(wr_addr);
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still busy");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(ENTRIES))
    else $error("fill count beyond capacity");

  a_evict_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.evicted |-> fill_r == CNT_W'(ENTRIES))
    else $error("eviction while table not full");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not start work");

endmodule

// ===== test/tb_timestamp_evicting_key_cache.sv =====
module tb_timestamp_evicting_key_cache;
  import tekc_pkg::*;

  localparam int WATCHDOG_CYCLES = 5000;
  localparam int DRAIN_CYCLES    = ENTRIES + 64;
  localparam int FILL_SLOTS      = 360;
  localparam int MIX_ITEMS       = 160;
  localparam int QUIET_ITEMS     = 40;

  class cache_checker;
    logic [KEY_BITS-1:0]   stored_keys   [ENTRIES];
    logic [VALUE_BITS-1:0] stored_values [ENTRIES];
    logic [STAMP_W-1:0]    stored_stamps [ENTRIES];
    int   used_slots;
    out_t pending_replies[$];
    int   failures;

    function new();
      used_slots = 0;
      failures   = 0;
    endfunction

    // Runs the access against the local copy of the table and queues the reply.
    function void predict_access(in_t beat);
      out_t                reply;
      logic [KEY_BITS-1:0] k;
      logic [STAMP_W-1:0]  oldest;
      int                  match;
      int                  target;
      reply = '0;
      k     = beat.key[KEY_BITS-1:0];
      match = -1;
      for (int i = 0; i < used_slots; i++) begin
        if (stored_keys[i] == k) begin
          match = i;
          break;
        end
      end
      if (beat.action == ACT_LOOKUP) begin
        if (match >= 0) begin
          reply.hit         = 1'b1;
          reply.slot        = match[SLOT_W-1:0];
          reply.found_value = 64'(stored_values[match]);
          reply.found_stamp = stored_stamps[match];
        end
      end else begin
        if (match >= 0) begin
          target    = match;
          reply.hit = 1'b1;
        end else if (used_slots < ENTRIES) begin
          target = used_slots;
          used_slots++;
        end else begin
          // only stamps strictly under the limit win; all at the limit -> slot 0
          oldest = STAMP_LIMIT;
          target = 0;
          for (int i = 0; i < ENTRIES; i++) begin
            if (stored_stamps[i] < oldest) begin
              oldest = stored_stamps[i];
              target = i;
            end
          end
          reply.evicted = 1'b1;
        end
        reply.slot            = target[SLOT_W-1:0];
        stored_keys[target]   = k;
        stored_values[target] = beat.value[VALUE_BITS-1:0];
        stored_stamps[target] = beat.stamp;
      end
      pending_replies.push_back(reply);
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        failures++;
        if (failures <= 10)
          $display("%s mismatch: expected %h, got %h", field, want, got);
      end
    endfunction

    function void check_response(out_t got);
      out_t want;
      if (pending_replies.size() == 0) begin
        failures++;
        if (failures <= 10) $display("result beat with nothing pending: %h", got);
        return;
      end
      want = pending_replies.pop_front();
      compare_field("hit", 64'(want.hit), 64'(got.hit));
      compare_field("evicted", 64'(want.evicted), 64'(got.evicted));
      compare_field("slot", 64'(want.slot), 64'(got.slot));
      compare_field("found_value", want.found_value, got.found_value);
      compare_field("found_stamp", 64'(want.found_stamp), 64'(got.found_stamp));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic out_valid;
  in_t  in_item;
  out_t out_item;

  cache_checker tracker;
  bit           quiet_sender;
  int           idle_cycles = 0;

  timestamp_evicting_key_cache u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) tracker.check_response(out_item);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_CYCLES) begin
      $display("timestamp_evicting_key_cache verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // small values make stamp ties common
  function automatic logic [STAMP_W-1:0] pick_stamp();
    case ($urandom_range(0, 7))
      0, 1:    return STAMP_W'($urandom_range(0, 7));
      2:       return STAMP_LIMIT;
      default: return STAMP_W'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] known_key();
    return 64'(tracker.stored_keys[$urandom_range(0, tracker.used_slots - 1)]);
  endfunction

  task automatic drive(logic act, logic [63:0] key, logic [STAMP_W-1:0] stamp,
                       logic [63:0] value);
    in_t beat;
    int  gap;
    beat.action = act;
    beat.key    = key;
    beat.stamp  = stamp;
    beat.value  = value;
    if (!quiet_sender && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start   = 1'b1;
    in_item = beat;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.predict_access(beat);
  endtask

  initial begin
    int roll;
    tracker      = new();
    clk          = 1'b0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_item      = '0;
    quiet_sender = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty table, key and stamp extremes, in-place overwrite
    drive(ACT_LOOKUP, 64'h0, pick_stamp(), rand64());
    drive(ACT_UPDATE, 64'h0, '0, '1);
    drive(ACT_UPDATE, '1, STAMP_LIMIT, '0);
    drive(ACT_LOOKUP, 64'h0, '0, '0);
    drive(ACT_LOOKUP, '1, '1, '1);
    drive(ACT_UPDATE, 64'h0, STAMP_LIMIT, rand64());
    drive(ACT_LOOKUP, 64'h0, '0, '0);
    drive(ACT_LOOKUP, rand64(), '0, '0);
    drive(ACT_UPDATE, '1, STAMP_LIMIT, '1);

    // fill part of the table
    while (tracker.used_slots < FILL_SLOTS) begin
      roll = $urandom_range(0, 99);
      if (roll < 88) drive(ACT_UPDATE, rand64(), pick_stamp(), rand64());
      else if (roll < 93) drive(ACT_UPDATE, known_key(), pick_stamp(), rand64());
      else if (roll < 97) drive(ACT_LOOKUP, known_key(), pick_stamp(), rand64());
      else drive(ACT_LOOKUP, rand64(), pick_stamp(), rand64());
    end

    for (int n = 0; n < MIX_ITEMS; n++) begin
      quiet_sender = (n >= MIX_ITEMS - QUIET_ITEMS);
      roll = $urandom_range(0, 99);
      if (roll < 30) drive(ACT_UPDATE, rand64(), pick_stamp(), rand64());
      else if (roll < 60) drive(ACT_UPDATE, known_key(), pick_stamp(), rand64());
      else if (roll < 85) drive(ACT_LOOKUP, known_key(), pick_stamp(), rand64());
      else drive(ACT_LOOKUP, rand64(), pick_stamp(), rand64());
    end

    @(negedge clk);
    start = 1'b0;
    while (tracker.pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending_replies.size() == 0) begin
      $display("timestamp_evicting_key_cache verification clean");
    end else begin
      $display("timestamp_evicting_key_cache verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tekc_pkg.sv
design/timestamp_evicting_key_cache.sv
test/tb_timestamp_evicting_key_cache.sv
